// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/krst_pkg.sv
package krst_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DUR_W   = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned USED_W  = 6;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 208;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   parse_sum;
    logic [SUM_W-1:0]   process_sum;
    logic [DUR_W-1:0]   parse_peak;
    logic [DUR_W-1:0]   process_peak;
  } krst_entry_t;

  // The key sits in the lowest bits, as on the request bus.
  typedef struct packed {
    logic [DUR_W-1:0] process_dur;
    logic [DUR_W-1:0] parse_dur;
    logic [KEY_W-1:0] key;
  } krst_req_t;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic hit;
    logic full;
  } krst_ctrl_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [DUR_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - DUR_W){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// File: rtl/core/keyed_request_statistics_table_core.sv
// Each request passes through the accept, compare, update and result steps in turn,
// and a new request is taken only once the result step has loaded the output register;
// the compare and update steps are shared by the whole cell chain.
// A waiting result holds the block in the result step, so no new request is taken meanwhile.
// Reset clears the entry count, the control state and the output valid at once;
// the table contents are not cleared.
`include "assert_macros.svh"

module keyed_request_statistics_table_core
  import krst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // request_key, parse_duration, process_duration
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status, entry_position, sample_count, parse_total, process_total,
  // parse_peak, process_peak, entries_used, zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;
  localparam logic [1:0] PH_RES  = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic             out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  krst_req_t        req_q;
  krst_ctrl_t       ctrl;

  logic [TABLE_ENTRIES-1:0] lt_vec, eq_vec, sel_vec, valid_vec;
  krst_entry_t entries [TABLE_ENTRIES];
  krst_entry_t masked  [TABLE_ENTRIES];

  logic        accept, hit, full, res_load;
  krst_entry_t res_entry;
  logic [IDX_W-1:0] res_pos;
  logic [31:0] pos_wide, used_wide;
  logic        res_drop, upd_insert;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (phase_q == PH_IDLE);
  assign hit = |eq_vec;
  assign full = (used_q == CNT_W'(TABLE_ENTRIES));
  assign res_load = (phase_q == PH_RES) && (!out_valid_q || m_axis_tready_i);

  assign ctrl.cmp_en = (phase_q == PH_CMP);
  assign ctrl.upd_en = (phase_q == PH_UPD);
  assign ctrl.hit = hit;
  assign ctrl.full = full;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= s_axis_tdata_i;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign valid_vec[i] = (CNT_W'(i) < used_q);
    if (i == 0) begin : g_head
      krst_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .req_i       (req_q),
        .valid_i     (valid_vec[i]),
        .prev_lt_i   (1'b1),
        .prev_entry_i('0),
        .lt_o        (lt_vec[i]),
        .eq_o        (eq_vec[i]),
        .sel_o       (sel_vec[i]),
        .entry_o     (entries[i]),
        .masked_o    (masked[i])
      );
    end else begin : g_body
      krst_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .req_i       (req_q),
        .valid_i     (valid_vec[i]),
        .prev_lt_i   (lt_vec[i-1]),
        .prev_entry_i(entries[i-1]),
        .lt_o        (lt_vec[i]),
        .eq_o        (eq_vec[i]),
        .sel_o       (sel_vec[i]),
        .entry_o     (entries[i]),
        .masked_o    (masked[i])
      );
    end
  end

  // At most one cell is selected, so an OR over the masked entries picks it out.
  always_comb begin
    res_entry = '0;
    res_pos = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      res_entry = res_entry | masked[i];
      if (sel_vec[i]) begin
        res_pos = res_pos | IDX_W'(i);
      end
    end
  end

  assign pos_wide = 32'(res_pos);
  assign used_wide = 32'(used_q);

  always_comb begin
    phase_d = phase_q;
    used_d = used_q;
    status_d = status_q;
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          phase_d = PH_CMP;
        end
      end
      PH_CMP: begin
        phase_d = PH_UPD;
      end
      PH_UPD: begin
        if (hit) begin
          status_d = ST_UPDATED;
        end else if (full) begin
          status_d = ST_DROPPED;
        end else begin
          status_d = ST_INSERTED;
          used_d = used_q + 1'b1;
        end
        phase_d = PH_RES;
      end
      PH_RES: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          out_data_d = {3'b000, used_wide[USED_W-1:0],
                        res_entry.process_peak, res_entry.parse_peak,
                        res_entry.process_sum, res_entry.parse_sum,
                        res_entry.count, pos_wide[POS_W-1:0], status_q};
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      used_q <= '0;
      status_q <= ST_UPDATED;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      used_q <= used_d;
      status_q <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_data_q;

  assign res_drop = (phase_q == PH_RES) && (status_q == ST_DROPPED);
  assign upd_insert = (phase_q == PH_UPD) && !hit && !full;

  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= CNT_W'(TABLE_ENTRIES))
  `ASSERT_IMPLIES(a_sel_onehot, clk_i, rst_ni, phase_q == PH_RES, $onehot0(sel_vec))
  `ASSERT_IMPLIES(a_drop_full, clk_i, rst_ni, res_drop, full && (sel_vec == '0))
  `ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, upd_insert, used_q == $past(used_q) + 1'b1)

endmodule

// File: rtl/core/krst_cell.sv
module krst_cell
  import krst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  krst_ctrl_t  ctrl_i,
  input  krst_req_t   req_i,
  input  logic        valid_i,
  input  logic        prev_lt_i,
  input  krst_entry_t prev_entry_i,
  output logic        lt_o,
  output logic        eq_o,
  output logic        sel_o,
  output krst_entry_t entry_o,
  output krst_entry_t masked_o
);

  logic        lt_q, lt_d, eq_q, eq_d, sel_q, sel_d;
  krst_entry_t entry_q, entry_d, bumped, fresh;
  logic        do_upd, do_ins, do_shift;

  always_comb begin
    bumped = entry_q;
    bumped.count = (&entry_q.count) ? entry_q.count : entry_q.count + 1'b1;
    bumped.parse_sum = sat_sum(entry_q.parse_sum, req_i.parse_dur);
    bumped.process_sum = sat_sum(entry_q.process_sum, req_i.process_dur);
    if (req_i.parse_dur > entry_q.parse_peak) begin
      bumped.parse_peak = req_i.parse_dur;
    end
    if (req_i.process_dur > entry_q.process_peak) begin
      bumped.process_peak = req_i.process_dur;
    end

    fresh.key = req_i.key;
    fresh.count = COUNT_W'(1);
    fresh.parse_sum = {{(SUM_W - DUR_W){1'b0}}, req_i.parse_dur};
    fresh.process_sum = {{(SUM_W - DUR_W){1'b0}}, req_i.process_dur};
    fresh.parse_peak = req_i.parse_dur;
    fresh.process_peak = req_i.process_dur;
  end

  // The insertion point is the first cell whose key is not below the request.
  assign do_upd   = ctrl_i.upd_en && ctrl_i.hit && eq_q;
  assign do_ins   = ctrl_i.upd_en && !ctrl_i.hit && !ctrl_i.full && !lt_q && prev_lt_i;
  assign do_shift = ctrl_i.upd_en && !ctrl_i.hit && !ctrl_i.full && !prev_lt_i;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    sel_d = sel_q;
    entry_d = entry_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid_i && (entry_q.key < req_i.key);
      eq_d = valid_i && (entry_q.key == req_i.key);
    end
    if (ctrl_i.upd_en) begin
      sel_d = do_upd || do_ins;
    end
    if (do_upd) begin
      entry_d = bumped;
    end else if (do_ins) begin
      entry_d = fresh;
    end else if (do_shift) begin
      entry_d = prev_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign lt_o = lt_q;
  assign eq_o = eq_q;
  assign sel_o = sel_q;
  assign entry_o = entry_q;
  assign masked_o = sel_q ? entry_q : '0;

endmodule

// File: bench/keyed_request_statistics_table_checker.sv
`timescale 1ns / 1ps

module keyed_request_statistics_table_checker
  import krst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // request_key, parse_duration, process_duration
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // status, entry_position, sample_count, parse_total, process_total,
  // parse_peak, process_peak, entries_used, zero padding
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           outstanding_o
);

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   parse_total;
    logic [SUM_W-1:0]   process_total;
    logic [DUR_W-1:0]   parse_peak;
    logic [DUR_W-1:0]   process_peak;
    logic [USED_W-1:0]  used;
  } stats_result_t;

  krst_entry_t   stats_table [TABLE_ENTRIES];
  int unsigned   entries_held;
  stats_result_t expected_stats_q [$];
  int unsigned   mismatches;

  // Applies one request to the local copy of the table and returns the figures
  // the block should report for it.
  function automatic stats_result_t tally_request(input krst_req_t req);
    stats_result_t res;
    krst_entry_t   ent;
    int unsigned   pos;
    logic [SUM_W:0] wide;
    res = '0;
    pos = 0;
    while (pos < entries_held && stats_table[pos].key < req.key) pos++;
    if (pos < entries_held && stats_table[pos].key == req.key) begin
      res.status = ST_UPDATED;
      ent = stats_table[pos];
    end else if (entries_held >= TABLE_ENTRIES) begin
      // A full table drops the sample and reports zeros beside the status and the entries used.
      res.status = ST_DROPPED;
      res.used = USED_W'(entries_held);
      return res;
    end else begin
      for (int unsigned j = entries_held; j > pos; j--) stats_table[j] = stats_table[j-1];
      ent = '0;
      ent.key = req.key;
      entries_held++;
      res.status = ST_INSERTED;
    end
    if (ent.count != '1) ent.count = ent.count + 1'b1;
    wide = ent.parse_sum + req.parse_dur;
    ent.parse_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    wide = ent.process_sum + req.process_dur;
    ent.process_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    if (req.parse_dur > ent.parse_peak) ent.parse_peak = req.parse_dur;
    if (req.process_dur > ent.process_peak) ent.process_peak = req.process_dur;
    stats_table[pos] = ent;
    res.position      = POS_W'(pos);
    res.count         = ent.count;
    res.parse_total   = ent.parse_sum;
    res.process_total = ent.process_sum;
    res.parse_peak    = ent.parse_peak;
    res.process_peak  = ent.process_peak;
    res.used          = USED_W'(entries_held);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    krst_req_t     req;
    stats_result_t exp_res;
    if (!rst_ni) begin
      entries_held = 0;
      expected_stats_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_stats_q.size() == 0) begin
          mismatches++;
          $error("result with no request waiting");
        end else begin
          exp_res = expected_stats_q.pop_front();
          compare_field("status", exp_res.status, m_axis_tdata_i[1:0]);
          compare_field("entry_position", exp_res.position, m_axis_tdata_i[6:2]);
          compare_field("sample_count", exp_res.count, m_axis_tdata_i[38:7]);
          compare_field("parse_total", exp_res.parse_total, m_axis_tdata_i[86:39]);
          compare_field("process_total", exp_res.process_total, m_axis_tdata_i[134:87]);
          compare_field("parse_peak", exp_res.parse_peak, m_axis_tdata_i[166:135]);
          compare_field("process_peak", exp_res.process_peak, m_axis_tdata_i[198:167]);
          compare_field("entries_used", exp_res.used, m_axis_tdata_i[204:199]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        req.key         = s_axis_tdata_i[63:0];
        req.parse_dur   = s_axis_tdata_i[95:64];
        req.process_dur = s_axis_tdata_i[127:96];
        expected_stats_q.push_back(tally_request(req));
      end
      mismatch_count_o <= mismatches;
      outstanding_o <= expected_stats_q.size();
    end
  end

endmodule

// File: bench/keyed_request_statistics_table_core_tb.sv
`timescale 1ns / 1ps

module keyed_request_statistics_table_core_tb;
  import krst_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1270;
  // A short run of one key sent back to back with full-scale durations.
  localparam int unsigned STEADY_REQUESTS = 24;
  localparam int unsigned POOL_SIZE = 40;
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MID = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_SAT = 64'h5555_aaaa_0000_ffff;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned     mismatch_count;
  int unsigned     outstanding;
  longint unsigned cycle_count = 0;
  int unsigned     burst_left = 0;
  bit              steady_sender = 1'b0;
  int unsigned     stall_mode = 0;
  int unsigned     stall_span = 0;
  int unsigned     stall_phase = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [KEY_W-1:0] known_keys [6];

  keyed_request_statistics_table_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  keyed_request_statistics_table_checker stats_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The result side switches between always ready, coin flips, rare acceptance
  // and a regular on/off pattern.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    stall_phase++;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((stall_phase % 16) < 5);
    endcase
  end

  task automatic send_request(input logic [KEY_W-1:0] key, input logic [DUR_W-1:0] parse_dur,
                              input logic [DUR_W-1:0] process_dur);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= {process_dur, parse_dur, key};
    do @(posedge clk); while (!s_tready);
    if (steady_sender) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [DUR_W-1:0] random_duration();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DUR_MAX;
      2: return DUR_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned pick;
    logic [KEY_W-1:0] key;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Extreme keys and durations, hits on both ends, inserts that shift entries.
    send_request('0, '0, '0);
    send_request(KEY_MAX, DUR_MAX, DUR_MAX);
    send_request('0, DUR_MAX, 32'd1);
    send_request('0, 32'd1, DUR_MAX);
    send_request(KEY_MID, 32'h0000_1234, 32'h0000_ffff);
    send_request(64'd1, 32'h8000_0000, 32'h7fff_ffff);
    send_request(KEY_MAX - 1, 32'd3, 32'd4);
    send_request(KEY_MAX, '0, '0);
    send_request(KEY_MID, 32'h0000_0010, 32'hffff_0000);
    send_request(64'd1, 32'h7fff_ffff, 32'h8000_0000);

    // One key fed full-scale durations with no gap between requests.
    steady_sender = 1'b1;
    for (int unsigned n = 0; n < STEADY_REQUESTS; n++) begin
      send_request(KEY_SAT, DUR_MAX, DUR_MAX);
    end
    send_request(KEY_SAT, '0, '0);
    send_request(KEY_SAT, DUR_MAX, 32'd5);
    steady_sender = 1'b0;

    // Let every outstanding request drain before the random part.
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    known_keys[0] = '0;
    known_keys[1] = 64'd1;
    known_keys[2] = KEY_MID;
    known_keys[3] = KEY_MAX - 1;
    known_keys[4] = KEY_MAX;
    known_keys[5] = KEY_SAT;
    for (int unsigned n = 0; n < POOL_SIZE; n++) key_pool[n] = {$urandom, $urandom};
    // Neighbours of keys already held, to test the ordering at close range.
    key_pool[0] = 64'd2;
    key_pool[1] = KEY_MAX - 2;
    key_pool[2] = KEY_MID - 1;
    key_pool[3] = KEY_MID + 1;
    key_pool[4] = KEY_SAT + 1;
    key_pool[5] = KEY_SAT - 1;

    // The pool is larger than the table, so once it fills the misses are dropped.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90) key = known_keys[$urandom_range(0, 5)];
      else key = {$urandom, $urandom};
      send_request(key, random_duration(), random_duration());
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
